// ----- sv/dmdts_pkg.sv -----
// Shared types and constants for the dual motor drive test sequencer.
// Request/result payload structs, opcodes, register indexes, test step codes.
`timescale 1ns / 1ps

package dmdts_pkg;

  localparam int PWM_BITS_DEF = 8;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_SET   = 2'd1,
    OP_STOP  = 2'd2,
    OP_START = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE_A    = 3'd0,
    CFG_SCALE_B    = 3'd1,
    CFG_RUN_TIME   = 3'd2,
    CFG_HALT_TIME  = 3'd3,
    CFG_PAUSE_TIME = 3'd4,
    CFG_MAX_LEVEL  = 3'd5,
    CFG_MID_LEVEL  = 3'd6,
    CFG_UNUSED     = 3'd7
  } cfg_idx_t;

  localparam logic [3:0] STEP_IDLE   = 4'd0;
  localparam logic [3:0] STEP_B_FWD  = 4'd1;
  localparam logic [3:0] STEP_B_STP1 = 4'd2;
  localparam logic [3:0] STEP_B_REV  = 4'd3;
  localparam logic [3:0] STEP_B_STP2 = 4'd4;
  localparam logic [3:0] STEP_A_FWD  = 4'd5;
  localparam logic [3:0] STEP_A_STP1 = 4'd6;
  localparam logic [3:0] STEP_A_REV  = 4'd7;
  localparam logic [3:0] STEP_A_STP2 = 4'd8;
  localparam logic [3:0] STEP_PAUSE  = 4'd9;

  typedef struct packed {
    op_t                op;
    logic signed [15:0] speed_a;
    logic signed [15:0] speed_b;
    logic               brake;
  } in_req_t;

  typedef struct packed {
    logic       in1_a;
    logic       in2_a;
    logic       in1_b;
    logic       in2_b;
    logic [7:0] duty_a;
    logic [7:0] duty_b;
    logic       test_running;
    logic [3:0] test_step;
  } out_res_t;

endpackage

// ----- sv/dual_motor_drive_test_sequencer_unit.sv -----
// Top level of the dual motor drive test sequencer.
// Depends on dmdts_pkg for payload structs, opcodes and step codes.
`timescale 1ns / 1ps

// Usage:
//   in_valid/in_data/in_stall carries one request per accepted cycle: a 1 ms
//   tick, a set-speed, a stop (brake or coast) or a test start.
//   out_valid/out_data/out_stall returns one result per request: bridge pin
//   levels, PWM duties, test running flag and current test step.
//   cfg_we/cfg_idx/cfg_wdata writes the scale, timing and level registers;
//   write only while no request is in flight.
// Path: a request is taken into the input register, then its result into the result register.
// Throughput: one request per cycle while the receiver does not stall; the state update is a single registered
//   pass through two 17x9 scale multipliers and the step timer compare.
// The receiver may stall: the result register holds, and the input register
//   keeps taking requests while the result register is free or being taken.
// Reset (synchronous, rst_n low): test idle at step 0, all pins low, duties
//   0, scales 256, all times and levels 0, both channels empty.
module dual_motor_drive_test_sequencer_unit #(
  parameter int PWM_BITS = dmdts_pkg::PWM_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  dmdts_pkg::in_req_t                   in_data,
  output logic                                 in_stall,
  output logic                                 out_valid,
  output dmdts_pkg::out_res_t                  out_data,
  input  logic                                 out_stall,
  input  logic                                 cfg_we,
  input  dmdts_pkg::cfg_idx_t                  cfg_idx,
  input  logic [dmdts_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import dmdts_pkg::*;

  localparam logic [17:0] PwmMax = 18'((64'd1 << PWM_BITS) - 64'd1);

  // configuration
  logic [8:0]  scale_a_r, scale_b_r;
  logic [15:0] run_time_r, halt_time_r, pause_time_r;
  logic [7:0]  max_level_r, mid_level_r;

  // sequencer and bridge state
  logic [3:0]  step_r, step_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic        pending_r, pending_nxt;
  logic        active_r, active_nxt;
  logic [3:0]  pins_r, pins_nxt;     // bit0 in1_a, bit1 in2_a, bit2 in1_b, bit3 in2_b
  logic [7:0]  duty_a_r, duty_a_nxt;
  logic [7:0]  duty_b_r, duty_b_nxt;

  // pipeline
  logic      in_valid_r;
  in_req_t   in_data_r;
  logic      out_valid_r;
  out_res_t  out_data_r, out_data_nxt;
  logic      advance;

  // datapath
  logic signed [15:0] spd_a, spd_b, lvl_a, lvl_b, fwd_lvl, rev_lvl;
  logic        drv_a, drv_b, entry;
  logic [17:0] mag_a, mag_b;
  logic        neg_a, neg_b;
  logic [15:0] elapsed_inc, dur;

  function automatic logic [17:0] sat_mag(input logic signed [15:0] spd,
                                          input logic [8:0] scale);
    logic [16:0] mag;
    logic [25:0] prod;
    mag  = spd[15] ? 17'(-$signed({spd[15], spd})) : 17'(spd);
    prod = 26'(mag) * 26'(scale);
    return (prod[25:8] > PwmMax) ? PwmMax : prod[25:8];
  endfunction

  // {in2, in1}
  function automatic logic [1:0] pin_code(input logic [17:0] mag, input logic neg);
    if (mag == '0) return 2'b00;
    return neg ? 2'b01 : 2'b10;
  endfunction

  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_a_r    <= 9'd256;
      scale_b_r    <= 9'd256;
      run_time_r   <= '0;
      halt_time_r  <= '0;
      pause_time_r <= '0;
      max_level_r  <= '0;
      mid_level_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_SCALE_A:    scale_a_r    <= cfg_wdata[8:0];
        CFG_SCALE_B:    scale_b_r    <= cfg_wdata[8:0];
        CFG_RUN_TIME:   run_time_r   <= cfg_wdata;
        CFG_HALT_TIME:  halt_time_r  <= cfg_wdata;
        CFG_PAUSE_TIME: pause_time_r <= cfg_wdata;
        CFG_MAX_LEVEL:  max_level_r  <= cfg_wdata[7:0];
        CFG_MID_LEVEL:  mid_level_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign fwd_lvl     = $signed({8'd0, max_level_r});
  assign rev_lvl     = 16'(-$signed({8'd0, mid_level_r}));
  assign entry       = (in_data_r.op == OP_TICK) && active_r && pending_r;
  assign elapsed_inc = (elapsed_r == 16'hFFFF) ? elapsed_r : elapsed_r + 16'd1;

  always_comb begin
    lvl_a = '0;
    lvl_b = '0;
    unique case (step_r)
      STEP_B_FWD: lvl_b = fwd_lvl;
      STEP_B_REV: lvl_b = rev_lvl;
      STEP_A_FWD: lvl_a = fwd_lvl;
      STEP_A_REV: lvl_a = rev_lvl;
      default: ;
    endcase
  end

  // pause step is odd too, so it has to win over the run time
  always_comb begin
    priority case (1'b1)
      step_r == STEP_PAUSE: dur = pause_time_r;
      step_r[0]:            dur = run_time_r;
      default:              dur = halt_time_r;
    endcase
  end

  // speed source shared between set-speed requests and test step entries
  assign spd_a = (in_data_r.op == OP_SET) ? in_data_r.speed_a : lvl_a;
  assign spd_b = (in_data_r.op == OP_SET) ? in_data_r.speed_b : lvl_b;
  assign drv_a = (in_data_r.op == OP_SET) ||
                 (entry && step_r >= STEP_A_FWD && step_r <= STEP_A_STP2);
  assign drv_b = (in_data_r.op == OP_SET) ||
                 (entry && step_r >= STEP_B_FWD && step_r <= STEP_B_STP2);
  assign mag_a = sat_mag(spd_a, scale_a_r);
  assign mag_b = sat_mag(spd_b, scale_b_r);
  assign neg_a = !spd_a[15];    // motor A polarity is inverted
  assign neg_b = spd_b[15];

  always_comb begin
    step_nxt    = step_r;
    elapsed_nxt = elapsed_r;
    pending_nxt = pending_r;
    active_nxt  = active_r;
    pins_nxt    = pins_r;
    duty_a_nxt  = duty_a_r;
    duty_b_nxt  = duty_b_r;
    if (drv_a) begin
      pins_nxt[1:0] = pin_code(mag_a, neg_a);
      duty_a_nxt    = mag_a[7:0];
    end
    if (drv_b) begin
      pins_nxt[3:2] = pin_code(mag_b, neg_b);
      duty_b_nxt    = mag_b[7:0];
    end
    unique case (in_data_r.op)
      OP_TICK: begin
        if (active_r) begin
          pending_nxt = 1'b0;
          if (elapsed_inc >= dur) begin
            step_nxt    = (step_r == STEP_PAUSE) ? STEP_B_FWD : step_r + 4'd1;
            elapsed_nxt = '0;
            pending_nxt = 1'b1;
          end else begin
            elapsed_nxt = elapsed_inc;
          end
        end
      end
      OP_SET: ;
      OP_STOP: begin
        pins_nxt   = in_data_r.brake ? 4'hF : 4'h0;
        duty_a_nxt = '0;
        duty_b_nxt = '0;
      end
      OP_START: begin
        active_nxt  = 1'b1;
        step_nxt    = STEP_B_FWD;
        elapsed_nxt = '0;
        pending_nxt = 1'b1;
      end
      default: ;
    endcase

    out_data_nxt.in1_a        = pins_nxt[0];
    out_data_nxt.in2_a        = pins_nxt[1];
    out_data_nxt.in1_b        = pins_nxt[2];
    out_data_nxt.in2_b        = pins_nxt[3];
    out_data_nxt.duty_a       = duty_a_nxt;
    out_data_nxt.duty_b       = duty_b_nxt;
    out_data_nxt.test_running = active_nxt;
    out_data_nxt.test_step    = step_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      step_r      <= STEP_IDLE;
      elapsed_r   <= '0;
      pending_r   <= 1'b0;
      active_r    <= 1'b0;
      pins_r      <= '0;
      duty_a_r    <= '0;
      duty_b_r    <= '0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        step_r      <= step_nxt;
        elapsed_r   <= elapsed_nxt;
        pending_r   <= pending_nxt;
        active_r    <= active_nxt;
        pins_r      <= pins_nxt;
        duty_a_r    <= duty_a_nxt;
        duty_b_r    <= duty_b_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// ----- test/tb_dual_motor_drive_test_sequencer_unit.sv -----
// Self-checking testbench for dual_motor_drive_test_sequencer_unit.
// Holds a scoreboard that predicts pins, duties and test step per request.
// Depends on dmdts_pkg and the top level RTL only.
`timescale 1ns / 1ps

module tb_dual_motor_drive_test_sequencer_unit;
  import dmdts_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_ITEMS   = 150;
  localparam int RANDOM_PHASES = 8;

  // Predicts the driver state after every accepted request and checks results.
  class motor_drive_scoreboard;
    bit [8:0]  scale_a, scale_b;
    bit [15:0] run_ticks, halt_ticks, pause_ticks;
    bit [7:0]  fwd_level, rev_level;
    bit [3:0]  step;
    bit [15:0] elapsed;
    bit        entry_due;
    bit        running;
    bit        in1_a, in2_a, in1_b, in2_b;
    bit [7:0]  duty_a, duty_b;
    int unsigned pwm_top = (1 << PWM_BITS_DEF) - 1;
    out_res_t  pending_outputs[$];
    int        errors;
    int        accepted;
    int        checked;

    function void reset_state();
      scale_a = 9'd256; scale_b = 9'd256;
      run_ticks = '0; halt_ticks = '0; pause_ticks = '0;
      fwd_level = '0; rev_level = '0;
      step = STEP_IDLE; elapsed = '0; entry_due = 1'b0; running = 1'b0;
      {in1_a, in2_a, in1_b, in2_b} = 4'b0000;
      duty_a = '0; duty_b = '0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [15:0] val);
      case (idx)
        CFG_SCALE_A:    scale_a = val[8:0];
        CFG_SCALE_B:    scale_b = val[8:0];
        CFG_RUN_TIME:   run_ticks = val;
        CFG_HALT_TIME:  halt_ticks = val;
        CFG_PAUSE_TIME: pause_ticks = val;
        CFG_MAX_LEVEL:  fwd_level = val[7:0];
        CFG_MID_LEVEL:  rev_level = val[7:0];
        default: ;
      endcase
    endfunction

    function void drive_motor(bit is_a, int speed);
      int unsigned mag;
      bit          neg;
      bit [8:0]    scl;
      bit [1:0]    pin_pair;
      scl = is_a ? scale_a : scale_b;
      neg = speed < 0;
      mag = neg ? -speed : speed;
      mag = (mag * scl) >> 8;
      if (mag > pwm_top) mag = pwm_top;
      // motor A is wired with reversed polarity
      if (is_a) neg = !neg;
      if (mag == 0) pin_pair = 2'b00;
      else if (neg) pin_pair = 2'b10;
      else pin_pair = 2'b01;
      if (is_a) begin
        {in1_a, in2_a} = pin_pair;
        duty_a = mag[7:0];
      end else begin
        {in1_b, in2_b} = pin_pair;
        duty_b = mag[7:0];
      end
    endfunction

    function void advance_tick();
      bit [15:0] dur;
      if (!running) return;
      if (elapsed != 16'hFFFF) elapsed++;
      if (entry_due) begin
        case (step)
          STEP_B_FWD:               drive_motor(1'b0, int'(fwd_level));
          STEP_B_REV:               drive_motor(1'b0, -int'(rev_level));
          STEP_B_STP1, STEP_B_STP2: drive_motor(1'b0, 0);
          STEP_A_FWD:               drive_motor(1'b1, int'(fwd_level));
          STEP_A_REV:               drive_motor(1'b1, -int'(rev_level));
          STEP_A_STP1, STEP_A_STP2: drive_motor(1'b1, 0);
          default: ;
        endcase
        entry_due = 1'b0;
      end
      if (step == STEP_PAUSE) dur = pause_ticks;
      else if (step[0]) dur = run_ticks;
      else dur = halt_ticks;
      if (elapsed >= dur) begin
        step = (step == STEP_PAUSE) ? STEP_B_FWD : step + 4'd1;
        elapsed = '0;
        entry_due = 1'b1;
      end
    endfunction

    function void note_request(in_req_t req);
      out_res_t exp;
      int       sa, sb;
      sa = req.speed_a;
      sb = req.speed_b;
      case (req.op)
        OP_TICK: advance_tick();
        OP_SET: begin
          drive_motor(1'b1, sa);
          drive_motor(1'b0, sb);
        end
        OP_STOP: begin
          {in1_a, in2_a, in1_b, in2_b} = req.brake ? 4'b1111 : 4'b0000;
          duty_a = '0;
          duty_b = '0;
        end
        default: begin
          running = 1'b1;
          step = STEP_B_FWD;
          elapsed = '0;
          entry_due = 1'b1;
        end
      endcase
      exp.in1_a = in1_a;
      exp.in2_a = in2_a;
      exp.in1_b = in1_b;
      exp.in2_b = in2_b;
      exp.duty_a = duty_a;
      exp.duty_b = duty_b;
      exp.test_running = running;
      exp.test_step = step;
      pending_outputs.push_back(exp);
      accepted++;
    endfunction

    function string describe(out_res_t r);
      return $sformatf("pins A %b%b B %b%b duty A %0d B %0d running %b step %0d",
                       r.in1_a, r.in2_a, r.in1_b, r.in2_b, r.duty_a, r.duty_b,
                       r.test_running, r.test_step);
    endfunction

    function void check_output(out_res_t got);
      out_res_t exp;
      if (pending_outputs.size() == 0) begin
        errors++;
        if (errors <= 40) $display("%0t: unexpected result %s", $time, describe(got));
        return;
      end
      exp = pending_outputs.pop_front();
      checked++;
      if (got.in1_a !== exp.in1_a || got.in2_a !== exp.in2_a ||
          got.in1_b !== exp.in1_b || got.in2_b !== exp.in2_b ||
          got.duty_a !== exp.duty_a || got.duty_b !== exp.duty_b ||
          got.test_running !== exp.test_running || got.test_step !== exp.test_step) begin
        errors++;
        if (errors <= 40) begin
          $display("%0t: mismatch on result %0d", $time, checked);
          $display("  expected %s", describe(exp));
          $display("  actual   %s", describe(got));
        end
      end
    endfunction

    function int pending();
      return pending_outputs.size();
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  in_req_t  in_data = '0;
  logic     in_stall;
  logic     out_valid;
  out_res_t out_data;
  logic     out_stall = 1'b0;
  logic     cfg_we = 1'b0;
  cfg_idx_t cfg_idx = CFG_SCALE_A;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  motor_drive_scoreboard sb = new();
  int cycle_count = 0;
  int hold_cycles = 0;
  bit calm_phase = 1'b0;
  int cfg_writes = 0;

  dual_motor_drive_test_sequencer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic in_req_t make_req(op_t op, int sa, int sb_speed, bit brk);
    in_req_t r;
    r.op = op;
    r.speed_a = sa[15:0];
    r.speed_b = sb_speed[15:0];
    r.brake = brk;
    return r;
  endfunction

  function automatic logic signed [15:0] random_speed();
    logic signed [15:0] v;
    case ($urandom_range(0, 3))
      0: v = 16'($urandom);
      1: v = 16'($urandom_range(0, 600) - 300);
      2: begin
        case ($urandom_range(0, 4))
          0: v = 16'sh7FFF;
          1: v = 16'sh8000;
          2: v = 16'sh0000;
          3: v = 16'sh0001;
          default: v = 16'shFFFF;
        endcase
      end
      default: v = 16'($urandom_range(0, 4000) - 2000);
    endcase
    return v;
  endfunction

  function automatic in_req_t random_request();
    in_req_t r;
    int pct;
    pct = $urandom_range(0, 99);
    if (pct < 70) r.op = OP_TICK;
    else if (pct < 82) r.op = OP_SET;
    else if (pct < 92) r.op = OP_STOP;
    else r.op = OP_START;
    r.speed_a = random_speed();
    r.speed_b = random_speed();
    r.brake = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // Called at a clock edge; returns at the edge where the request is taken.
  task automatic send_request(in_req_t r);
    int gap;
    gap = calm_phase ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_cfg(cfg_idx_t idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_writes++;
  endtask

  task automatic program_regs(logic [15:0] sa, logic [15:0] sbv, logic [15:0] run_t,
                              logic [15:0] halt_t, logic [15:0] pause_t,
                              logic [15:0] fwd, logic [15:0] rev);
    // idle gap after the drain before the writes
    wait_drained();
    repeat (2) @(posedge clk);
    write_cfg(CFG_SCALE_A, sa);
    write_cfg(CFG_SCALE_B, sbv);
    write_cfg(CFG_RUN_TIME, run_t);
    write_cfg(CFG_HALT_TIME, halt_t);
    write_cfg(CFG_PAUSE_TIME, pause_t);
    write_cfg(CFG_MAX_LEVEL, fwd);
    write_cfg(CFG_MID_LEVEL, rev);
    write_cfg(CFG_UNUSED, 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  // result side: per-result stall draw plus an occasional long hold-off
  initial begin
    int stall_cycles;
    while (!rst_n) @(posedge clk);
    forever begin
      stall_cycles = (calm_phase ? 0 : $urandom_range(0, 6)) + hold_cycles;
      hold_cycles = 0;
      if (stall_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (stall_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      sb.check_output(out_data);
    end
  end

  initial begin
    logic [15:0] sa, sbv, run_t, halt_t, pause_t, fwd, rev;
    sb.reset_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, speed extremes, brake/coast, idle tick, start
    send_request(make_req(OP_TICK, 0, 0, 1'b0));
    send_request(make_req(OP_SET, 32767, -32768, 1'b0));
    send_request(make_req(OP_SET, -1, 1, 1'b1));
    send_request(make_req(OP_SET, 0, 0, 1'b0));
    send_request(make_req(OP_STOP, -1, -1, 1'b1));
    send_request(make_req(OP_STOP, 0, 0, 1'b0));
    send_request(make_req(OP_START, 0, 0, 1'b0));
    send_request(make_req(OP_TICK, 0, 0, 1'b0));

    // directed: full sequence with short steps, commands during the test
    program_regs(16'd511, 16'd1, 16'd1, 16'd0, 16'd2, 16'd255, 16'd128);
    send_request(make_req(OP_SET, -256, 32767, 1'b0));
    send_request(make_req(OP_START, 0, 0, 1'b0));
    repeat (12) send_request(make_req(OP_TICK, 0, 0, 1'b0));
    send_request(make_req(OP_SET, 100, -100, 1'b0));
    send_request(make_req(OP_START, 0, 0, 1'b0));
    send_request(make_req(OP_STOP, 0, 0, 1'b1));
    send_request(make_req(OP_TICK, 0, 0, 1'b0));

    for (int p = 1; p <= RANDOM_PHASES; p++) begin
      sa = (p == 1) ? 16'd0 : (p == 2) ? 16'd511 : 16'($urandom_range(0, 511));
      sbv = (p == 1) ? 16'd511 : (p == 2) ? 16'd0 : 16'($urandom_range(0, 511));
      run_t = (p == 4) ? 16'hFFFF : 16'($urandom_range(0, 4));
      halt_t = 16'($urandom_range(0, 4));
      pause_t = (p == 6) ? 16'hFFFF : 16'($urandom_range(0, 4));
      if (p == 3) begin
        run_t = '0;
        halt_t = '0;
        pause_t = '0;
      end
      fwd = (p == 1 || p == 5) ? 16'd255 : (p == 2) ? 16'd0 : 16'($urandom_range(0, 255));
      rev = (p == 1) ? 16'd255 : (p == 2 || p == 5) ? 16'd0 : 16'($urandom_range(0, 255));
      program_regs(sa, sbv, run_t, halt_t, pause_t, fwd, rev);
      calm_phase = (p % 3 == 0);
      // long output hold-off so the pipeline backs up into in_stall
      if (p == 3 || p == 7) hold_cycles = 250;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 5 && i == PHASE_ITEMS / 2) wait_drained();
        send_request(random_request());
      end
    end

    wait_drained();
    calm_phase = 1'b0;
    repeat (4) @(posedge clk);
    $display("covered %0d requests, %0d results checked, %0d register writes",
             sb.accepted, sb.checked, cfg_writes);
    $display("settings: %0d random phases incl. scale/level/duration extremes", RANDOM_PHASES);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d failures", sb.errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
